// ===== rtl/core/rnss_pkg.sv =====
// shared widths and command codes for the radius neighbor search block
package rnss_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned DIST_W = 50;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

endpackage

// ===== rtl/core/radius_neighbor_search_sorted.sv =====
// top level of the radius neighbor search block with sorted result output
//
// Keeps TABLE_SLOTS points of three signed COORD_BITS coordinates in one
// synchronous memory plus an occupied bit per slot. A request is taken when
// start_i is high and busy_o is low. Insert, remove and the unused command
// give their single result on the next cycle. A query walks the memory one
// slot per cycle (one read port), runs each point through a four stage
// distance pipe (memory read, difference, square, then sum and compare),
// and drops each hit into a row of sorting cells that keeps matches in
// ascending distance, lower slot first on ties. Once the pipe has drained
// the cells shift out one result per cycle; a query that finds nothing
// gives one result with valid_res_o low, and busy_o falls as the final
// result is shown. Results are strobed by res_strobe_o for exactly one cycle
// each, back to back within a query; the receiver cannot hold them off, and
// last_o marks the final result of each request.
module radius_neighbor_search_sorted #(
  parameter int unsigned TABLE_SLOTS = 64,
  parameter int unsigned COORD_BITS  = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [rnss_pkg::CMD_W-1:0]          cmd_i,
  input  logic [rnss_pkg::SLOT_W-1:0]         slot_i,
  input  logic                                exclude_self_i,
  input  logic signed [COORD_BITS-1:0]        pos_x_i,
  input  logic signed [COORD_BITS-1:0]        pos_y_i,
  input  logic signed [COORD_BITS-1:0]        pos_z_i,
  input  logic [COORD_BITS-1:0]               search_radius_i,
  output logic                                res_strobe_o,
  output logic                                status_o,
  output logic                                valid_res_o,
  output logic [rnss_pkg::SLOT_W-1:0]         neighbor_slot_o,
  output logic [rnss_pkg::DIST_W-1:0]         distance_squared_o,
  output logic                                last_o
);

  localparam int unsigned IW = $clog2(TABLE_SLOTS);      // slot index width
  localparam int unsigned NW = $clog2(TABLE_SLOTS + 1);  // match count width
  localparam int unsigned AW = COORD_BITS + 1;           // abs difference width
  localparam int unsigned SW = 2 * AW;                   // square and sum width
  localparam int unsigned DW = 2 * COORD_BITS;           // stored match distance
  localparam int unsigned PW = 3 * COORD_BITS;           // packed point width

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_e;

  state_e state_q;

  // request decode
  logic accept;
  logic in_table;
  logic query_start;
  assign accept      = start_i && (state_q == S_IDLE);
  assign in_table    = {1'b0, slot_i} < (rnss_pkg::SLOT_W + 1)'(TABLE_SLOTS);
  assign query_start = accept && (cmd_i == rnss_pkg::CMD_QUERY);
  assign busy_o      = (state_q != S_IDLE);

  // query operands held for the whole scan
  logic signed [COORD_BITS-1:0] qx_q, qy_q, qz_q;
  logic [DW-1:0]                r2_q;
  logic [rnss_pkg::SLOT_W-1:0]  ex_slot_q;
  logic                         ex_en_q;

  always_ff @(posedge clk_i) begin
    if (query_start) begin
      qx_q      <= pos_x_i;
      qy_q      <= pos_y_i;
      qz_q      <= pos_z_i;
      r2_q      <= DW'(search_radius_i * search_radius_i);
      ex_slot_q <= slot_i;
      ex_en_q   <= exclude_self_i;
    end
  end

  // point memory, one read port used by the scan, written by insert
  logic [PW-1:0] pt_mem [TABLE_SLOTS];
  logic [PW-1:0] pt_rd_q;
  logic [IW-1:0] idx_q;
  logic          pt_we;
  assign pt_we = accept && (cmd_i == rnss_pkg::CMD_INSERT) && in_table;

  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[slot_i[IW-1:0]] <= {pos_x_i, pos_y_i, pos_z_i};
    end
    pt_rd_q <= pt_mem[idx_q];
  end

  // occupied bits
  logic [TABLE_SLOTS-1:0] occ_q;
  logic                   remove_ok;
  assign remove_ok = in_table && occ_q[slot_i[IW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else if (accept && in_table) begin
      if (cmd_i == rnss_pkg::CMD_INSERT) begin
        occ_q[slot_i[IW-1:0]] <= 1'b1;
      end else if (cmd_i == rnss_pkg::CMD_REMOVE) begin
        occ_q[slot_i[IW-1:0]] <= 1'b0;
      end
    end
  end

  // scan issue: slot counts along with the memory read
  logic scan_use;
  assign scan_use = occ_q[idx_q] &&
                    !(ex_en_q && (ex_slot_q == rnss_pkg::SLOT_W'(idx_q)));

  // distance pipe control
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic s1_use_q, s2_use_q, s3_use_q, s4_hit_q;
  logic [IW-1:0] s1_slot_q, s2_slot_q, s3_slot_q, s4_slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= (state_q == S_SCAN);
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  // distance pipe data
  logic signed [COORD_BITS-1:0] px, py, pz;
  logic signed [AW-1:0]         dx, dy, dz;
  logic [AW-1:0]                s2_ax_q, s2_ay_q, s2_az_q;
  logic [SW-1:0]                s3_sx_q, s3_sy_q, s3_sz_q;
  logic [SW-1:0]                sum;
  logic [DW-1:0]                s4_dist_q;

  assign px  = pt_rd_q[PW-1 -: COORD_BITS];
  assign py  = pt_rd_q[2*COORD_BITS-1 -: COORD_BITS];
  assign pz  = pt_rd_q[COORD_BITS-1:0];
  assign dx  = AW'(qx_q) - AW'(px);
  assign dy  = AW'(qy_q) - AW'(py);
  assign dz  = AW'(qz_q) - AW'(pz);
  assign sum = s3_sx_q + s3_sy_q + s3_sz_q;

  always_ff @(posedge clk_i) begin
    s1_use_q  <= scan_use;
    s1_slot_q <= idx_q;
    // abs differences, at most 2^COORD_BITS - 1
    s2_use_q  <= s1_use_q;
    s2_slot_q <= s1_slot_q;
    s2_ax_q   <= dx[AW-1] ? AW'(-dx) : AW'(dx);
    s2_ay_q   <= dy[AW-1] ? AW'(-dy) : AW'(dy);
    s2_az_q   <= dz[AW-1] ? AW'(-dz) : AW'(dz);
    // squares
    s3_use_q  <= s2_use_q;
    s3_slot_q <= s2_slot_q;
    s3_sx_q   <= s2_ax_q * s2_ax_q;
    s3_sy_q   <= s2_ay_q * s2_ay_q;
    s3_sz_q   <= s2_az_q * s2_az_q;
    // sum and radius test; a hit always fits the stored width
    s4_hit_q  <= s3_use_q && (sum <= SW'(r2_q));
    s4_slot_q <= s3_slot_q;
    s4_dist_q <= sum[DW-1:0];
  end

  // sorting cells: hits enter in slot order, each lands after equal distances
  logic [DW-1:0]               cell_d_q [TABLE_SLOTS];
  logic [rnss_pkg::SLOT_W-1:0] cell_s_q [TABLE_SLOTS];
  logic [NW-1:0]               n_q;
  logic [TABLE_SLOTS-1:0]      gt;
  logic                        cell_ins;
  logic                        cell_pop;

  assign cell_ins = s4_vld_q && s4_hit_q;
  assign cell_pop = (state_q == S_EMIT) && (n_q != '0);

  always_comb begin
    for (int k = 0; k < TABLE_SLOTS; k++) begin
      gt[k] = (NW'(k) >= n_q) || (cell_d_q[k] > s4_dist_q);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < TABLE_SLOTS; k++) begin
      if (cell_ins && gt[k]) begin
        if (k == 0 || !gt[(k == 0) ? 0 : k-1]) begin
          cell_d_q[k] <= s4_dist_q;
          cell_s_q[k] <= rnss_pkg::SLOT_W'(s4_slot_q);
        end else begin
          cell_d_q[k] <= cell_d_q[(k == 0) ? 0 : k-1];
          cell_s_q[k] <= cell_s_q[(k == 0) ? 0 : k-1];
        end
      end else if (cell_pop && k < TABLE_SLOTS - 1) begin
        cell_d_q[k] <= cell_d_q[(k < TABLE_SLOTS - 1) ? k+1 : k];
        cell_s_q[k] <= cell_s_q[(k < TABLE_SLOTS - 1) ? k+1 : k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else if (query_start) begin
      n_q <= '0;
    end else if (cell_ins) begin
      n_q <= n_q + NW'(1);
    end else if (cell_pop) begin
      n_q <= n_q - NW'(1);
    end
  end

  // head cell with output saturation
  logic [63:0]                 head_ext;
  logic [rnss_pkg::DIST_W-1:0] head_dist;
  assign head_ext  = 64'(cell_d_q[0]);
  assign head_dist = (head_ext > 64'(rnss_pkg::DIST_MAX)) ? rnss_pkg::DIST_MAX
                                                          : head_ext[rnss_pkg::DIST_W-1:0];

  // sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= S_IDLE;
      idx_q              <= '0;
      res_strobe_o       <= 1'b0;
      status_o           <= 1'b0;
      valid_res_o        <= 1'b0;
      neighbor_slot_o    <= '0;
      distance_squared_o <= '0;
      last_o             <= 1'b0;
    end else begin
      res_strobe_o       <= 1'b0;
      status_o           <= 1'b0;
      valid_res_o        <= 1'b0;
      neighbor_slot_o    <= '0;
      distance_squared_o <= '0;
      last_o             <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (cmd_i == rnss_pkg::CMD_QUERY) begin
              idx_q   <= '0;
              state_q <= S_SCAN;
            end else begin
              // insert, remove and the unused command answer at once
              res_strobe_o <= 1'b1;
              last_o       <= 1'b1;
              status_o     <= (cmd_i == rnss_pkg::CMD_REMOVE) && !remove_ok;
            end
          end
        end
        S_SCAN: begin
          idx_q <= idx_q + IW'(1);
          if (idx_q == IW'(TABLE_SLOTS - 1)) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!s1_vld_q && !s2_vld_q && !s3_vld_q && !s4_vld_q) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          res_strobe_o <= 1'b1;
          if (n_q == '0) begin
            // empty match
            last_o  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            valid_res_o        <= 1'b1;
            neighbor_slot_o    <= cell_s_q[0];
            distance_squared_o <= head_dist;
            if (n_q == NW'(1)) begin
              last_o  <= 1'b1;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/rnss_checker.sv =====
// port level checks for the radius neighbor search block and their bind
module rnss_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic [rnss_pkg::CMD_W-1:0]  cmd_i,
  input logic                        res_strobe_o,
  input logic                        status_o,
  input logic                        valid_res_o,
  input logic                        last_o
);

  // table updates and the unused command answer on the next cycle with a single result
  a_update_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (cmd_i != rnss_pkg::CMD_QUERY) |=> res_strobe_o && last_o)
    else $error("update request did not answer next cycle");

  // query results come out back to back
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !last_o |=> res_strobe_o)
    else $error("gap inside a result burst");

  // a match never carries a failure status
  a_match_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && valid_res_o |-> !status_o)
    else $error("match with failure status");

  // a result without a match ends its request
  a_nomatch_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !valid_res_o |-> last_o)
    else $error("no-match result not last");

  // block is free while its final result is shown
  a_free_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && last_o |-> !busy_o)
    else $error("still busy on final result");

endmodule

bind radius_neighbor_search_sorted rnss_checker u_rnss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .cmd_i        (cmd_i),
  .res_strobe_o (res_strobe_o),
  .status_o     (status_o),
  .valid_res_o  (valid_res_o),
  .last_o       (last_o)
);
